FILE: hdl/arq_pkg.sv
// Shared widths, table geometry, config register codes and the
// controller/datapath command and status types for average_reward_q_update.
// No dependencies.
`default_nettype none

package arq_pkg;

    localparam int STATE_W   = 8;
    localparam int ACT_W     = 4;
    localparam int ADDR_W    = STATE_W + ACT_W;
    localparam int TBL_DEPTH = 2 ** ADDR_W;
    localparam int VAL_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int RATE_W    = 17;
    localparam int NS_W      = 9;
    localparam int NA_W      = 5;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int DIFF_W    = VAL_W + 2;
    localparam int PROD_W    = DIFF_W + RATE_W + 1;
    localparam int SUM_W     = PROD_W - FRAC_W;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(TBL_DEPTH - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA   = 2'd0,
        CFG_RHO     = 2'd1,
        CFG_STATES  = 2'd2,
        CFG_ACTIONS = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NXT_SCAN,
        ST_NXT_WAIT,
        ST_DIFF,
        ST_MUL,
        ST_WRITE,
        ST_CUR_SCAN,
        ST_CUR_WAIT,
        ST_CHECK,
        ST_AVG_MUL,
        ST_AVG_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              load;
        logic              clear_wr;
        logic              scan_rd;
        logic              scan_cur;
        logic              rd_entry;
        logic              diff_next;
        logic              mul_en;
        logic              mul_rho;
        logic              write_entry;
        logic              check;
        logic              avg_add;
        logic              emit;
        logic [ADDR_W-1:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic range_ok;
        logic scan_last;
        logic hit;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: hdl/average_reward_q_update.sv
// Top level of the average-reward tabular value update.
// Depends on arq_pkg, arq_ctrl and arq_datapath.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_cur_state i_action_taken i_next_state i_reward
//  output   | o_out_valid  | i_out_stall  | o_new_value o_average_reward o_average_updated
//  config   | i_cfg_we     | -            | i_cfg_index i_cfg_data
//
// One transaction at a time; each runs two row scans over the actions in use through the
// single table read port, plus an average multiply/add step when the average moves.
// The next input can be taken in the cycle after the result is loaded.
// An out-of-range transaction skips the scans and goes straight to ST_DONE to load its result.
// After reset a clear pass zeroes all 4096 table entries; input is stalled meanwhile.
// The output register lets the next transaction be accepted while a result is stalled.
`default_nettype none

module average_reward_q_update import arq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [STATE_W-1:0]      i_cur_state,
    input  wire logic [ACT_W-1:0]        i_action_taken,
    input  wire logic [STATE_W-1:0]      i_next_state,
    input  wire logic signed [VAL_W-1:0] i_reward,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic signed [VAL_W-1:0]      o_new_value,
    output logic signed [VAL_W-1:0]      o_average_reward,
    output logic                         o_average_updated
);

    t_dp_cmd    cmd;
    t_dp_status status;

    arq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    arq_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cur_state       (i_cur_state),
        .i_action_taken    (i_action_taken),
        .i_next_state      (i_next_state),
        .i_reward          (i_reward),
        .o_new_value       (o_new_value),
        .o_average_reward  (o_average_reward),
        .o_average_updated (o_average_updated),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall)
    );

endmodule

`default_nettype wire

FILE: hdl/arq_ctrl.sv
// Sequencer for the value update: clear pass, two row scans, the entry
// update, the average update on a row-max hit, and result hand-off. Depends on arq_pkg.
`default_nettype none

module arq_ctrl import arq_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.cnt  = r_cnt;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                n_cnt          = r_cnt + ADDR_W'(1);
                if (r_cnt == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.range_ok ? ST_NXT_SCAN : ST_DONE;
                end
            end
            ST_NXT_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_cnt         = r_cnt + ADDR_W'(1);
                if (i_status.scan_last) begin
                    n_cnt   = '0;
                    n_state = ST_NXT_WAIT;
                end
            end
            ST_NXT_WAIT: begin
                o_cmd.rd_entry = 1'b1;
                n_state        = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff_next = 1'b1;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write_entry = 1'b1;
                n_state           = ST_CUR_SCAN;
            end
            ST_CUR_SCAN: begin
                o_cmd.scan_rd  = 1'b1;
                o_cmd.scan_cur = 1'b1;
                n_cnt          = r_cnt + ADDR_W'(1);
                if (i_status.scan_last) begin
                    n_cnt   = '0;
                    n_state = ST_CUR_WAIT;
                end
            end
            ST_CUR_WAIT: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.hit ? ST_AVG_MUL : ST_DONE;
            end
            ST_AVG_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_rho = 1'b1;
                n_state       = ST_AVG_ADD;
            end
            ST_AVG_ADD: begin
                o_cmd.avg_add = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result loaded while output register busy");

    a_scan_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NXT_SCAN || r_state == ST_CUR_SCAN) |-> r_cnt[ADDR_W-1:ACT_W] == '0)
        else $error("scan counter left the row");

    a_avg_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AVG_MUL) |-> ($past(r_state) == ST_CHECK && $past(i_status.hit)))
        else $error("average update without row-max hit");

    a_clear_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && $past(r_state) == ST_CLEAR) |-> $past(r_cnt) == CLR_LAST)
        else $error("clear pass ended early");

endmodule

`default_nettype wire

FILE: hdl/arq_datapath.sv
// Value table memory, config registers, row-max tracking, shared rate
// multiplier, saturating accumulators and the output register. Depends on arq_pkg.
`default_nettype none

module arq_datapath import arq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_status                   o_status,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic [STATE_W-1:0]      i_cur_state,
    input  wire logic [ACT_W-1:0]        i_action_taken,
    input  wire logic [STATE_W-1:0]      i_next_state,
    input  wire logic signed [VAL_W-1:0] i_reward,
    output logic signed [VAL_W-1:0]      o_new_value,
    output logic signed [VAL_W-1:0]      o_average_reward,
    output logic                         o_average_updated,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall
);

    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);
    localparam logic [NS_W-1:0]   NS_MAX   = NS_W'(2 ** STATE_W);
    localparam logic [NA_W-1:0]   NA_MAX   = NA_W'(2 ** ACT_W);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (VAL_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
        sat_val = (v > SAT_HI) ? SAT_HI[VAL_W-1:0] :
                  (v < SAT_LO) ? SAT_LO[VAL_W-1:0] : v[VAL_W-1:0];
    endfunction

    logic signed [VAL_W-1:0] mem [0:TBL_DEPTH-1];

    logic [RATE_W-1:0]       r_alpha, r_rho;
    logic [NS_W-1:0]         r_states;
    logic [NA_W-1:0]         r_actions;
    logic [STATE_W-1:0]      r_s, r_s1;
    logic [ACT_W-1:0]        r_a;
    logic signed [VAL_W-1:0] r_rew, r_avg;
    logic signed [VAL_W-1:0] r_rd_data, r_best, r_nbest, r_old, r_entry;
    logic                    r_rd_live, r_rd_first, r_moved;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0] r_out_value, r_out_avg;
    logic                    r_out_moved, r_out_valid;

    logic [RATE_W-1:0]       alpha_eff, rho_eff, mul_rate;
    logic [NS_W-1:0]         ns_eff;
    logic [NA_W-1:0]         na_eff;
    logic [ADDR_W-1:0]       idx, rd_addr, wr_addr;
    logic [STATE_W-1:0]      scan_row;
    logic                    rd_en, wr_en;
    logic signed [VAL_W-1:0] wr_data, entry_sat, avg_sat;
    logic signed [SUM_W-1:0] prod_sh, entry_sum, avg_sum;
    logic signed [DIFF_W-1:0] rew_x, avg_x, best_x, nbest_x, diff_next, diff_avg;
    logic signed [PROD_W-1:0] prod;

    assign alpha_eff = (r_alpha > RATE_ONE) ? RATE_ONE : r_alpha;
    assign rho_eff   = (r_rho > RATE_ONE) ? RATE_ONE : r_rho;
    assign ns_eff    = (r_states == '0) ? NS_W'(1) : (r_states > NS_MAX) ? NS_MAX : r_states;
    assign na_eff    = (r_actions == '0) ? NA_W'(1) : (r_actions > NA_MAX) ? NA_MAX : r_actions;

    assign idx      = {r_s, r_a};
    assign scan_row = i_cmd.scan_cur ? r_s : r_s1;
    assign rd_addr  = i_cmd.scan_rd ? {scan_row, i_cmd.cnt[ACT_W-1:0]} : idx;
    assign rd_en    = i_cmd.scan_rd | i_cmd.rd_entry;
    assign wr_en    = i_cmd.clear_wr | i_cmd.write_entry;
    assign wr_addr  = i_cmd.clear_wr ? i_cmd.cnt : idx;
    assign wr_data  = i_cmd.clear_wr ? '0 : entry_sat;

    assign rew_x   = {{(DIFF_W-VAL_W){r_rew[VAL_W-1]}}, r_rew};
    assign avg_x   = {{(DIFF_W-VAL_W){r_avg[VAL_W-1]}}, r_avg};
    assign best_x  = {{(DIFF_W-VAL_W){r_best[VAL_W-1]}}, r_best};
    assign nbest_x = {{(DIFF_W-VAL_W){r_nbest[VAL_W-1]}}, r_nbest};
    assign diff_next = rew_x - avg_x + best_x;
    assign diff_avg  = rew_x + nbest_x - best_x;

    assign mul_rate = i_cmd.mul_rho ? rho_eff : alpha_eff;
    assign prod     = PROD_W'(r_diff) * PROD_W'($signed({1'b0, mul_rate}));

    // arithmetic shift floors toward minus infinity
    assign prod_sh   = $signed(r_prod[PROD_W-1:FRAC_W]);
    assign entry_sum = $signed({{(SUM_W-VAL_W){r_old[VAL_W-1]}}, r_old}) + prod_sh;
    assign avg_sum   = $signed({{(SUM_W-VAL_W){r_avg[VAL_W-1]}}, r_avg}) + prod_sh;
    assign entry_sat = sat_val(entry_sum);
    assign avg_sat   = sat_val(avg_sum);

    assign o_status.range_ok  = ({1'b0, i_cur_state} < ns_eff) &&
                                ({1'b0, i_next_state} < ns_eff) &&
                                ({1'b0, i_action_taken} < na_eff);
    assign o_status.scan_last = ({1'b0, i_cmd.cnt[ACT_W-1:0]} == na_eff - NA_W'(1));
    assign o_status.hit       = (r_entry == r_best);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= RATE_W'(6554);
            r_rho     <= RATE_W'(655);
            r_states  <= NS_MAX;
            r_actions <= NA_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ALPHA:   r_alpha   <= i_cfg_data[RATE_W-1:0];
                CFG_RHO:     r_rho     <= i_cfg_data[RATE_W-1:0];
                CFG_STATES:  r_states  <= i_cfg_data[NS_W-1:0];
                CFG_ACTIONS: r_actions <= i_cfg_data[NA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg       <= '0;
            r_rd_live   <= 1'b0;
            r_rd_first  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_live  <= i_cmd.scan_rd;
            r_rd_first <= i_cmd.scan_rd && (i_cmd.cnt[ACT_W-1:0] == '0);
            if (i_cmd.avg_add) begin
                r_avg <= avg_sat;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s     <= i_cur_state;
            r_a     <= i_action_taken;
            r_s1    <= i_next_state;
            r_rew   <= i_reward;
            r_entry <= '0;
            r_moved <= 1'b0;
        end
        if (r_rd_live && (r_rd_first || r_rd_data > r_best)) begin
            r_best <= r_rd_data;
        end
        if (i_cmd.diff_next) begin
            r_old   <= r_rd_data;
            r_nbest <= r_best;
            r_diff  <= diff_next;
        end
        if (i_cmd.check) begin
            r_diff <= diff_avg;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
        end
        if (i_cmd.write_entry) begin
            r_entry <= entry_sat;
        end
        if (i_cmd.avg_add) begin
            r_moved <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_out_value <= r_entry;
            r_out_avg   <= r_avg;
            r_out_moved <= r_moved;
        end
    end

    assign o_new_value       = r_out_value;
    assign o_average_reward  = r_out_avg;
    assign o_average_updated = r_out_moved;
    assign o_out_valid       = r_out_valid;

endmodule

`default_nettype wire
